/* src/tsv_pkg.sv */
// Shared types and constants for the ticker symbol validator.
package tsv_pkg;

    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 6;
    localparam int COUNT_W      = 7;
    localparam int STATUS_W     = 4;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [LEN_W-1:0]   MAX_LENGTH_RESET = 6'd12;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 7'd127;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_D0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_D9     = 8'h39;
    localparam logic [BYTE_W-1:0] CASE_OFS  = 8'h20;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 4'd0,
        ST_NORM      = 4'd1,
        ST_EMPTY     = 4'd2,
        ST_UNSUP     = 4'd3,
        ST_CLEANUP   = 4'd4,
        ST_NO_LETTER = 4'd5,
        ST_TOO_LONG  = 4'd6,
        ST_BAD_ENDS  = 4'd7,
        ST_BAD_PUNCT = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ALNUM = 2'd1,
        KIND_PUNCT = 2'd2
    } t_kind;

    typedef enum logic {
        ITEM_CHAR    = 1'b0,
        ITEM_VERDICT = 1'b1
    } t_item;

    typedef struct packed {
        logic              has_char;
        logic [BYTE_W-1:0] ch;
        logic              has_verdict;
        t_status           status;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

/* src/tsv_if.sv */
// Channel interfaces: symbol input, result output and configuration write.
interface tsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       no_byte;
    logic       end_of_symbol;
    modport source (output valid, in_byte, no_byte, end_of_symbol, input ready);
    modport sink (input valid, in_byte, no_byte, end_of_symbol, output ready);
endinterface

interface tsv_out_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] out_char;
    logic [3:0] status;
    logic       is_last;
    modport source (output valid, item_kind, out_char, status, is_last, input ready);
    modport sink (input valid, item_kind, out_char, status, is_last, output ready);
endinterface

interface tsv_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] max_length;
    modport source (output valid, max_length, input ready);
    modport sink (input valid, max_length, output ready);
endinterface

/* src/tsv_front.sv */
// Front end: accepts bytes, classifies and normalizes them, tracks symbol flags.
module tsv_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tsv_in_if.sink                    i_sym,
    input  logic [tsv_pkg::LEN_W-1:0] i_max_length,
    input  logic                      i_full,
    output tsv_pkg::t_push            o_push
);
    import tsv_pkg::*;

    logic               r_seen, n_seen;
    logic               r_pending, n_pending;
    logic               r_bad, n_bad;
    logic               r_letter, n_letter;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_first, n_first;
    t_kind              r_prev, n_prev;
    logic               r_pair, n_pair;
    logic               r_changed, n_changed;

    logic [BYTE_W-1:0] b;
    logic is_space, is_lower, is_upper, is_digit, is_slash, is_dotdash, is_good, is_alnum;
    logic has_char, drop_dollar, take;
    logic [BYTE_W-1:0] ch;
    t_kind   kind;
    t_status verdict;

    assign i_sym.ready = !i_full;
    assign take        = i_sym.valid && !i_full;
    assign b           = i_sym.in_byte;

    assign is_space   = (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
    assign is_lower   = b >= CH_LO_A && b <= CH_LO_Z;
    assign is_upper   = b >= CH_UP_A && b <= CH_UP_Z;
    assign is_digit   = b >= CH_D0 && b <= CH_D9;
    assign is_slash   = b == CH_SLASH;
    assign is_dotdash = b == CH_DOT || b == CH_DASH;
    assign is_alnum   = is_lower || is_upper || is_digit;
    assign is_good    = is_alnum || is_slash || is_dotdash;
    assign kind       = is_alnum ? KIND_ALNUM : KIND_PUNCT;

    always_comb begin
        if (is_lower) begin
            ch = b - CASE_OFS;
        end else if (is_slash) begin
            ch = CH_DOT;
        end else begin
            ch = b;
        end
    end

    always_comb begin
        n_seen      = r_seen;
        n_pending   = r_pending;
        n_bad       = r_bad;
        n_letter    = r_letter;
        n_count     = r_count;
        n_first     = r_first;
        n_prev      = r_prev;
        n_pair      = r_pair;
        n_changed   = r_changed;
        has_char    = 1'b0;
        drop_dollar = !r_seen && b == CH_DOLLAR;
        if (!i_sym.no_byte) begin
            if (is_space) begin
                if (r_seen) begin
                    n_pending = 1'b1;
                end
            end else begin
                n_seen    = 1'b1;
                n_pending = 1'b0;
                if (r_pending || drop_dollar) begin
                    n_changed = 1'b1;
                end
                if (!drop_dollar) begin
                    if (!is_good) begin
                        n_bad = 1'b1;
                    end else begin
                        has_char = 1'b1;
                        if (is_lower || is_slash) begin
                            n_changed = 1'b1;
                        end
                        if (is_lower || is_upper) begin
                            n_letter = 1'b1;
                        end
                        if (r_count == '0) begin
                            n_first = is_alnum;
                        end
                        if (kind == KIND_PUNCT && r_prev == KIND_PUNCT) begin
                            n_pair = 1'b1;
                        end
                        n_prev = kind;
                        if (r_count != COUNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        if (!n_seen) begin
            verdict = ST_EMPTY;
        end else if (n_bad) begin
            verdict = ST_UNSUP;
        end else if (n_count == '0) begin
            verdict = ST_CLEANUP;
        end else if (!n_letter) begin
            verdict = ST_NO_LETTER;
        end else if (n_count > {1'b0, i_max_length}) begin
            verdict = ST_TOO_LONG;
        end else if (!n_first || n_prev != KIND_ALNUM) begin
            verdict = ST_BAD_ENDS;
        end else if (n_pair) begin
            verdict = ST_BAD_PUNCT;
        end else begin
            verdict = n_changed ? ST_NORM : ST_OK;
        end
    end

    always_comb begin
        o_push.push              = take && (has_char || i_sym.end_of_symbol);
        o_push.entry.has_char    = has_char;
        o_push.entry.ch          = ch;
        o_push.entry.has_verdict = i_sym.end_of_symbol;
        o_push.entry.status      = verdict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_sym.end_of_symbol)) begin
            r_seen    <= 1'b0;
            r_pending <= 1'b0;
            r_bad     <= 1'b0;
            r_letter  <= 1'b0;
            r_count   <= '0;
            r_first   <= 1'b0;
            r_prev    <= KIND_NONE;
            r_pair    <= 1'b0;
            r_changed <= 1'b0;
        end else if (take) begin
            r_seen    <= n_seen;
            r_pending <= n_pending;
            r_bad     <= n_bad;
            r_letter  <= n_letter;
            r_count   <= n_count;
            r_first   <= n_first;
            r_prev    <= n_prev;
            r_pair    <= n_pair;
            r_changed <= n_changed;
        end
    end

endmodule

/* src/tsv_fifo.sv */
// Short queue between the front and back ends.
module tsv_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = r_cnt == FULL;
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* src/tsv_back.sv */
// Back end: unpacks queue entries into character and verdict transactions.
module tsv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsv_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    tsv_out_if.source       o_res
);
    import tsv_pkg::*;

    logic              r_ov, n_ov;
    t_item             r_kind, n_kind;
    logic [BYTE_W-1:0] r_char, n_char;
    t_status           r_status, n_status;
    logic              r_pend, n_pend;
    t_status           r_pend_st, n_pend_st;
    logic              load;

    assign load = !r_ov || o_res.ready;

    always_comb begin
        n_ov      = r_ov;
        n_kind    = r_kind;
        n_char    = r_char;
        n_status  = r_status;
        n_pend    = r_pend;
        n_pend_st = r_pend_st;
        o_pop     = 1'b0;
        if (load) begin
            if (r_pend) begin
                n_ov     = 1'b1;
                n_kind   = ITEM_VERDICT;
                n_char   = '0;
                n_status = r_pend_st;
                n_pend   = 1'b0;
            end else if (!i_empty) begin
                o_pop = 1'b1;
                n_ov  = 1'b1;
                if (i_entry.has_char) begin
                    n_kind    = ITEM_CHAR;
                    n_char    = i_entry.ch;
                    n_status  = ST_OK;
                    n_pend    = i_entry.has_verdict;
                    n_pend_st = i_entry.status;
                end else begin
                    n_kind   = ITEM_VERDICT;
                    n_char   = '0;
                    n_status = i_entry.status;
                end
            end else begin
                n_ov = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_ov   <= n_ov;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_char    <= n_char;
        r_status  <= n_status;
        r_pend_st <= n_pend_st;
    end

    assign o_res.valid     = r_ov;
    assign o_res.item_kind = r_kind;
    assign o_res.out_char  = r_char;
    assign o_res.status    = r_status;
    assign o_res.is_last   = r_kind == ITEM_VERDICT;

endmodule

/* src/ticker_symbol_validator.sv */
// Top level of the ticker symbol validator.
// Each result is written to the queue and then to the output register.
// Throughput: one input per cycle unless the queue is full; the output register gives
// one result per cycle while ready is high; a character-and-verdict item gives two.
// Queue depth sets how far the input runs ahead of a stalled output.
// Reset clears symbol state and queue, and sets max_length to 12.
module ticker_symbol_validator #(
    parameter int QUEUE_DEPTH = tsv_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsv_in_if.sink     i_sym,
    tsv_out_if.source  o_res,
    tsv_cfg_if.sink    i_cfg
);
    import tsv_pkg::*;

    logic [LEN_W-1:0] r_max_length;
    t_push            push;
    t_entry           head;
    logic             full, empty, pop;
    logic [$bits(t_entry)-1:0] head_bits;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg.valid) begin
            r_max_length <= i_cfg.max_length;
        end
    end

    tsv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sym        (i_sym),
        .i_max_length (r_max_length),
        .i_full       (full),
        .o_push       (push)
    );

    tsv_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_entry))
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push.push),
        .i_data  (push.entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_bits),
        .o_empty (empty)
    );

    assign head = t_entry'(head_bits);

    tsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ticker_symbol_validator: directed and random symbol streams.
module testbench;
    import tsv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 200;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int NUM_PHASES     = 6;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        t_item             kind;
        logic [BYTE_W-1:0] ch;
        t_status           status;
        logic              last;
    } t_sym_result;

    typedef struct {
        logic [BYTE_W-1:0] b;
        logic              nb;
        logic              eos;
    } t_sym_byte;

    typedef enum int {
        CC_UPPER, CC_LOWER, CC_DIGIT, CC_PUNCT, CC_SPACE, CC_DOLLAR, CC_ANY
    } t_char_cls;

    class symbol_checker;
        logic [LEN_W-1:0]   max_len;
        logic [COUNT_W-1:0] norm_count;
        t_kind              prev_kind;
        bit                 seen_nonspace;
        bit                 pending_space;
        bit                 bad_byte;
        bit                 letter_seen;
        bit                 first_alnum;
        bit                 punct_pair;
        bit                 changed;
        t_sym_result        awaited[$];
        int                 errors;

        function new();
            max_len = MAX_LENGTH_RESET;
            errors  = 0;
            clear_symbol();
        endfunction

        function void clear_symbol();
            seen_nonspace = 1'b0;
            pending_space = 1'b0;
            bad_byte      = 1'b0;
            letter_seen   = 1'b0;
            norm_count    = '0;
            first_alnum   = 1'b0;
            prev_kind     = KIND_NONE;
            punct_pair    = 1'b0;
            changed       = 1'b0;
        endfunction

        function bit normalize_byte(input logic [BYTE_W-1:0] b, output logic [BYTE_W-1:0] ch);
            t_kind k;
            ch = '0;
            if ((b >= CH_TAB && b <= CH_CR) || b == CH_SPACE) begin
                if (seen_nonspace)
                    pending_space = 1'b1;
                return 1'b0;
            end
            if (pending_space) begin
                changed       = 1'b1;
                pending_space = 1'b0;
            end
            if (!seen_nonspace) begin
                seen_nonspace = 1'b1;
                if (b == CH_DOLLAR) begin
                    changed = 1'b1;
                    return 1'b0;
                end
            end
            if (b >= CH_LO_A && b <= CH_LO_Z) begin
                ch          = b - CASE_OFS;
                changed     = 1'b1;
                letter_seen = 1'b1;
                k           = KIND_ALNUM;
            end else if (b >= CH_UP_A && b <= CH_UP_Z) begin
                ch          = b;
                letter_seen = 1'b1;
                k           = KIND_ALNUM;
            end else if (b >= CH_D0 && b <= CH_D9) begin
                ch = b;
                k  = KIND_ALNUM;
            end else if (b == CH_SLASH) begin
                ch      = CH_DOT;
                changed = 1'b1;
                k       = KIND_PUNCT;
            end else if (b == CH_DOT || b == CH_DASH) begin
                ch = b;
                k  = KIND_PUNCT;
            end else begin
                bad_byte = 1'b1;
                return 1'b0;
            end
            if (norm_count == 0)
                first_alnum = (k == KIND_ALNUM);
            if (k == KIND_PUNCT && prev_kind == KIND_PUNCT)
                punct_pair = 1'b1;
            prev_kind = k;
            if (norm_count != COUNT_MAX)
                norm_count = norm_count + 1'b1;
            return 1'b1;
        endfunction

        function t_status grade_symbol();
            if (!seen_nonspace) return ST_EMPTY;
            if (bad_byte) return ST_UNSUP;
            if (norm_count == 0) return ST_CLEANUP;
            if (!letter_seen) return ST_NO_LETTER;
            if (norm_count > {1'b0, max_len}) return ST_TOO_LONG;
            if (!first_alnum || prev_kind != KIND_ALNUM) return ST_BAD_ENDS;
            if (punct_pair) return ST_BAD_PUNCT;
            return changed ? ST_NORM : ST_OK;
        endfunction

        function void note_input(logic [BYTE_W-1:0] b, logic nb, logic eos);
            logic [BYTE_W-1:0] ch;
            if (!nb && normalize_byte(b, ch))
                awaited.insert(awaited.size(), t_sym_result'{ITEM_CHAR, ch, ST_OK, 1'b0});
            if (eos) begin
                awaited.insert(awaited.size(),
                               t_sym_result'{ITEM_VERDICT, '0, grade_symbol(), 1'b1});
                clear_symbol();
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic kind, logic [BYTE_W-1:0] ch,
                                   logic [STATUS_W-1:0] st, logic last);
            t_sym_result want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result kind=%0b char=%02h status=%0d last=%0b",
                                 kind, ch, st, last));
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind || ch !== want.ch || st !== want.status
                || last !== want.last)
                report($sformatf({"result mismatch: expected kind=%0b char=%02h status=%0d ",
                                  "last=%0b, got kind=%0b char=%02h status=%0d last=%0b"},
                                 want.kind, want.ch, want.status, want.last,
                                 kind, ch, st, last));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tsv_in_if  sym_if();
    tsv_out_if res_if();
    tsv_cfg_if cfg_if();

    ticker_symbol_validator DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_sym   (sym_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    symbol_checker sb = new();

    int src_max_gap  = 6;
    int sink_max_gap = 6;
    int items_sent   = 0;
    int quiet_cycles = 0;
    bit hold_req     = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.max_len = cfg_if.max_length;
            if (sym_if.valid && sym_if.ready)
                sb.note_input(sym_if.in_byte, sym_if.no_byte, sym_if.end_of_symbol);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.item_kind, res_if.out_char, res_if.status,
                                res_if.is_last);
        end
    end

    always @(posedge clk) begin
        if ((sym_if.valid && sym_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result consumer: random backpressure, plus a long hold-off on request
    initial begin : result_sink
        int gap;
        res_if.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            gap = $urandom_range(0, sink_max_gap);
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!(res_if.valid && res_if.ready));
        end
    end

    function automatic logic [BYTE_W-1:0] rand_char(t_char_cls cls);
        int r;
        case (cls)
            CC_UPPER:  return CH_UP_A + BYTE_W'($urandom_range(0, 25));
            CC_LOWER:  return CH_LO_A + BYTE_W'($urandom_range(0, 25));
            CC_DIGIT:  return CH_D0 + BYTE_W'($urandom_range(0, 9));
            CC_PUNCT: begin
                r = $urandom_range(0, 2);
                return (r == 0) ? CH_DOT : (r == 1) ? CH_DASH : CH_SLASH;
            end
            CC_SPACE: begin
                r = $urandom_range(0, 5);
                return (r == 5) ? CH_SPACE : CH_TAB + BYTE_W'(r);
            end
            CC_DOLLAR: return CH_DOLLAR;
            default:   return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic nb, input logic eos);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            sym_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sym_if.valid         <= 1'b1;
        sym_if.in_byte       <= b;
        sym_if.no_byte       <= nb;
        sym_if.end_of_symbol <= eos;
        do @(posedge clk); while (!sym_if.ready);
        if (!nb || eos)
            items_sent++;
    endtask

    task automatic send_symbol(input int body_max, input bit noisy, input bit very_long);
        t_sym_byte seq[$];
        int        len;
        int        i;
        bit        last_punct;
        t_char_cls cls;
        repeat ($urandom_range(0, 2))
            seq.insert(seq.size(), t_sym_byte'{rand_char(CC_SPACE), 1'b0, 1'b0});
        if (noisy) begin
            repeat ($urandom_range(1, 10)) begin
                if ($urandom_range(0, 9) == 0)
                    seq.insert(seq.size(), t_sym_byte'{rand_char(CC_ANY), 1'b1, 1'b0});
                else
                    seq.insert(seq.size(),
                               t_sym_byte'{rand_char(t_char_cls'($urandom_range(0, 6))),
                                           1'b0, 1'b0});
            end
        end else begin
            if ($urandom_range(0, 3) == 0)
                seq.insert(seq.size(), t_sym_byte'{CH_DOLLAR, 1'b0, 1'b0});
            len = very_long ? $urandom_range(128, 140) : $urandom_range(1, body_max);
            last_punct = 1'b1;
            for (i = 0; i < len; i++) begin
                if (i > 0 && $urandom_range(0, 19) == 0)
                    seq.insert(seq.size(), t_sym_byte'{rand_char(CC_SPACE), 1'b0, 1'b0});
                if ($urandom_range(0, 29) == 0)
                    seq.insert(seq.size(), t_sym_byte'{rand_char(CC_ANY), 1'b1, 1'b0});
                if (!last_punct && i < len - 1 && $urandom_range(0, 4) == 0)
                    cls = CC_PUNCT;
                else if ($urandom_range(0, 4) == 0)
                    cls = CC_DIGIT;
                else
                    cls = $urandom_range(0, 1) ? CC_UPPER : CC_LOWER;
                last_punct = (cls == CC_PUNCT);
                seq.insert(seq.size(), t_sym_byte'{rand_char(cls), 1'b0, 1'b0});
            end
        end
        repeat ($urandom_range(0, 2))
            seq.insert(seq.size(), t_sym_byte'{rand_char(CC_SPACE), 1'b0, 1'b0});
        if ($urandom_range(0, 1))
            seq[seq.size() - 1].eos = 1'b1;
        else
            seq.insert(seq.size(), t_sym_byte'{rand_char(CC_ANY), 1'b1, 1'b1});
        foreach (seq[k])
            send_byte(seq[k].b, seq[k].nb, seq[k].eos);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] value);
        cfg_if.max_length <= value;
        cfg_if.valid      <= 1'b1;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        sym_if.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int               phase;
        int               target;
        logic [LEN_W-1:0] len_cfg;
        sym_if.valid         <= 1'b0;
        sym_if.in_byte       <= '0;
        sym_if.no_byte       <= 1'b0;
        sym_if.end_of_symbol <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.max_length    <= '0;
        rst_n                <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed symbols, default max_length
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
        send_byte(CH_TAB, 1'b0, 1'b0);
        send_byte(CH_CR, 1'b0, 1'b1);
        send_byte(CH_DOLLAR, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(CH_LO_A, 1'b0, 1'b1);
        send_byte(CH_UP_Z, 1'b0, 1'b0);
        send_byte(CH_SPACE, 1'b0, 1'b0);
        send_byte(CH_LO_A + 8'd1, 1'b0, 1'b0);
        send_byte(CH_SLASH, 1'b0, 1'b0);
        send_byte(CH_D9, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(CH_UP_A + 8'd23, 1'b0, 1'b0);
        send_byte(CH_DOLLAR, 1'b0, 1'b1);
        send_byte(CH_DOLLAR, 1'b0, 1'b1);
        send_byte(CH_D0 + 8'd1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(CH_UP_A, 1'b0, 1'b0);
        send_byte(CH_DASH, 1'b0, 1'b1);
        send_byte(CH_UP_A, 1'b0, 1'b0);
        send_byte(CH_DOT, 1'b0, 1'b0);
        send_byte(CH_DASH, 1'b0, 1'b0);
        send_byte(CH_UP_A + 8'd1, 1'b0, 1'b1);
        send_byte(CH_UP_A + 8'd12, 1'b0, 1'b1);
        wait_idle();

        items_sent = 0;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       len_cfg = 6'd1;
                1:       len_cfg = 6'd63;
                2:       len_cfg = 6'd0;
                3:       len_cfg = MAX_LENGTH_RESET;
                4:       len_cfg = LEN_W'($urandom_range(2, 62));
                default: len_cfg = LEN_W'($urandom_range(3, 8));
            endcase
            write_max_length(len_cfg);
            src_max_gap  = (phase == 0 || phase == 3) ? 0 : 6;
            sink_max_gap = (phase == 2 || phase == 5) ? 0 : 6;
            if (phase == 0 || phase == 3)
                hold_req = 1'b1;
            target = items_sent + RANDOM_ITEMS / NUM_PHASES;
            if (phase == 1 || phase == 2)
                send_symbol(0, 1'b0, 1'b1);
            while (items_sent < target)
                send_symbol(int'(len_cfg) + 2, $urandom_range(0, 4) == 0, 1'b0);
            wait_idle();
        end

        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/tsv_pkg.sv
src/tsv_if.sv
src/tsv_front.sv
src/tsv_fifo.sv
src/tsv_back.sv
src/ticker_symbol_validator.sv
verif/testbench.sv
